[hw/rtl/sks_pkg.sv]
// ----------------------------------------------------------------------------
// sks_pkg: shared types and codes for the skipped key store
// Holds the command codes and the layout of one stored slot row.
// ----------------------------------------------------------------------------
`default_nettype none

package sks_pkg;

  localparam int CmdW     = 2;
  localparam int KeyW     = 256;
  localparam int NumW     = 32;
  localparam int StampW   = 32;
  localparam int PopW     = 5;
  localparam int SlotW    = 5;

  localparam logic [CmdW-1:0] CMD_FIND   = 2'd0;
  localparam logic [CmdW-1:0] CMD_INSERT = 2'd1;
  localparam logic [CmdW-1:0] CMD_POP    = 2'd2;

  // Request payload: 551 bits of fields, padded to 552.
  localparam int InDataW  = 552;
  // Response payload: 262 bits of fields, padded to 264.
  localparam int OutDataW = 264;

  // One slot of the table as held in the memory.
  typedef struct packed {
    logic              occ;
    logic [NumW-1:0]   num;
    logic [KeyW-1:0]   hdr;
    logic [KeyW-1:0]   mkey;
    logic [StampW-1:0] stamp;
  } sks_row_t;

endpackage

`default_nettype wire

[hw/rtl/skipped_key_store.sv]
// ----------------------------------------------------------------------------
// skipped_key_store: associative table of skipped message keys
// Find, insert with oldest-stamp eviction, and pop over a single slot memory.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_tvalid/in_tready/in_tdata, responses leave on
//   out_tvalid/out_tready/out_tdata; each request yields exactly one response.
//   All slot state (occupied bit, message number, header key, message key,
//   insertion stamp) lives in one memory row per slot with a registered
//   read, so the table is walked one slot per cycle.
//   A find stops at the first hit; an insert stops at the first free slot,
//   otherwise it scans every stamp to pick the oldest. One request is in
//   work at a time.
//   After reset the block sweeps the memory to zero, one row per cycle;
//   in_tready stays low during that sweep.
//   A finished response sits in the output register; the block takes the next
//   request while it waits. If the receiver stalls, a second finished response
//   is held inside until the output register empties.
// ----------------------------------------------------------------------------
`default_nettype none

module skipped_key_store #(
  parameter int ENTRIES = 32
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_tvalid,
  output logic                           in_tready,
  // cmd[1:0], hdr_key_w0..w3[257:2], msg_number[289:258],
  // msg_key_w0..w3[545:290], pop_slot[550:546], zero pad[551]
  input  wire  [sks_pkg::InDataW-1:0]    in_tdata,
  output logic                           out_tvalid,
  input  wire                            out_tready,
  // hit[0], result_slot[5:1], result_key_w0..w3[261:6], zero pad[263:262]
  output logic [sks_pkg::OutDataW-1:0]   out_tdata
);
  import sks_pkg::*;

  localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDXW:0]   ENT_C    = (IDXW+1)'(ENTRIES);
  localparam logic [IDXW-1:0] LAST_C   = IDXW'(ENTRIES - 1);
  localparam logic [31:0]     ENTRIES_W = 32'(ENTRIES);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_POPRD = 3'd3;
  localparam logic [2:0] ST_POPWB = 3'd4;
  localparam logic [2:0] ST_WRITE = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  // Slot memory, one row per slot.
  sks_row_t mem [ENTRIES];
  sks_row_t rdata_r;
  logic [IDXW-1:0] rd_addr;
  logic            we;
  logic [IDXW-1:0] waddr;
  sks_row_t        wdata;

  // Control state.
  logic [2:0]        state_r, state_nxt;
  logic [IDXW-1:0]   clr_r, clr_nxt;
  logic [IDXW:0]     issue_r, issue_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic [IDXW-1:0]   chk_idx_r, chk_idx_nxt;
  logic [StampW-1:0] clock_r, clock_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Captured request.
  logic [CmdW-1:0]   cmd_r;
  logic [KeyW-1:0]   hdr_r;
  logic [NumW-1:0]   num_r;
  logic [KeyW-1:0]   mkey_r;
  logic [PopW-1:0]   pop_r;

  // Scan bookkeeping and pending response.
  logic [IDXW-1:0]   best_idx_r, best_idx_nxt;
  logic [StampW-1:0] best_stamp_r, best_stamp_nxt;
  logic [IDXW-1:0]   target_r, target_nxt;
  logic              res_hit_r, res_hit_nxt;
  logic [SlotW-1:0]  res_slot_r, res_slot_nxt;
  logic [KeyW-1:0]   res_key_r, res_key_nxt;
  logic              out_hit_r, out_hit_nxt;
  logic [SlotW-1:0]  out_slot_r, out_slot_nxt;
  logic [KeyW-1:0]   out_key_r, out_key_nxt;

  logic              in_fire;
  logic [CmdW-1:0]   in_cmd;
  logic [PopW-1:0]   in_pop;
  logic              in_pop_ok;
  logic [IDXW-1:0]   pop_addr;
  logic              row_match;
  logic              take_best;
  logic              chk_last;
  sks_row_t          pop_row;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign in_cmd     = in_tdata[1:0];
  assign in_pop     = in_tdata[550:546];
  assign in_pop_ok  = (32'(in_pop) < ENTRIES_W);
  assign pop_addr   = IDXW'(pop_r);

  // A find hits an occupied slot whose number and whole header key agree.
  assign row_match  = rdata_r.occ && (rdata_r.num == num_r) && (rdata_r.hdr == hdr_r);
  // Oldest-stamp tracking: the first slot seeds it, later ones must be strictly
  // older, so ties keep the lower index.
  assign take_best  = (chk_idx_r == '0) || (rdata_r.stamp < best_stamp_r);
  assign chk_last   = (chk_idx_r == LAST_C);

  // A popped slot is cleared except for its stamp.
  always_comb begin
    pop_row       = '0;
    pop_row.stamp = rdata_r.stamp;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_key_r, out_slot_r, out_hit_r};

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    issue_nxt      = issue_r;
    chk_vld_nxt    = chk_vld_r;
    chk_idx_nxt    = chk_idx_r;
    clock_nxt      = clock_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    best_idx_nxt   = best_idx_r;
    best_stamp_nxt = best_stamp_r;
    target_nxt     = target_r;
    res_hit_nxt    = res_hit_r;
    res_slot_nxt   = res_slot_r;
    res_key_nxt    = res_key_r;
    out_hit_nxt    = out_hit_r;
    out_slot_nxt   = out_slot_r;
    out_key_nxt    = out_key_r;
    rd_addr        = '0;
    we             = 1'b0;
    waddr          = '0;
    wdata          = '0;

    case (state_r)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r;
        if (clr_r == LAST_C) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          res_hit_nxt  = 1'b0;
          res_slot_nxt = '0;
          res_key_nxt  = '0;
          issue_nxt    = '0;
          chk_vld_nxt  = 1'b0;
          case (in_cmd)
            CMD_FIND:   state_nxt = ST_SCAN;
            CMD_INSERT: state_nxt = ST_SCAN;
            CMD_POP:    state_nxt = in_pop_ok ? ST_POPRD : ST_FIN;
            default:    state_nxt = ST_FIN;
          endcase
        end
      end

      ST_SCAN: begin
        // Issue the next slot read while checking the slot read last cycle.
        if (issue_r < ENT_C) begin
          rd_addr     = issue_r[IDXW-1:0];
          issue_nxt   = issue_r + 1'b1;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = issue_r[IDXW-1:0];
        end else begin
          chk_vld_nxt = 1'b0;
        end
        if (chk_vld_r) begin
          if (cmd_r == CMD_FIND) begin
            if (row_match) begin
              res_hit_nxt  = 1'b1;
              res_slot_nxt = SlotW'(chk_idx_r);
              state_nxt    = ST_FIN;
            end else if (chk_last) begin
              state_nxt = ST_FIN;
            end
          end else begin
            if (!rdata_r.occ) begin
              target_nxt = chk_idx_r;
              state_nxt  = ST_WRITE;
            end else begin
              if (take_best) begin
                best_idx_nxt   = chk_idx_r;
                best_stamp_nxt = rdata_r.stamp;
              end
              if (chk_last) begin
                target_nxt = take_best ? chk_idx_r : best_idx_r;
                state_nxt  = ST_WRITE;
              end
            end
          end
        end
      end

      ST_POPRD: begin
        rd_addr   = pop_addr;
        state_nxt = ST_POPWB;
      end

      ST_POPWB: begin
        res_key_nxt = rdata_r.mkey;
        we          = 1'b1;
        waddr       = pop_addr;
        wdata       = pop_row;
        state_nxt   = ST_FIN;
      end

      ST_WRITE: begin
        we           = 1'b1;
        waddr        = target_r;
        wdata.occ    = 1'b1;
        wdata.num    = num_r;
        wdata.hdr    = hdr_r;
        wdata.mkey   = mkey_r;
        wdata.stamp  = clock_r + 1'b1;
        clock_nxt    = clock_r + 1'b1;
        res_slot_nxt = SlotW'(target_r);
        state_nxt    = ST_FIN;
      end

      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = res_hit_r;
          out_slot_nxt  = res_slot_r;
          out_key_nxt   = res_key_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[rd_addr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      issue_r     <= '0;
      chk_vld_r   <= 1'b0;
      chk_idx_r   <= '0;
      clock_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      issue_r     <= issue_nxt;
      chk_vld_r   <= chk_vld_nxt;
      chk_idx_r   <= chk_idx_nxt;
      clock_r     <= clock_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= in_cmd;
      hdr_r  <= in_tdata[257:2];
      num_r  <= in_tdata[289:258];
      mkey_r <= in_tdata[545:290];
      pop_r  <= in_pop;
    end
    best_idx_r   <= best_idx_nxt;
    best_stamp_r <= best_stamp_nxt;
    target_r     <= target_nxt;
    res_hit_r    <= res_hit_nxt;
    res_slot_r   <= res_slot_nxt;
    res_key_r    <= res_key_nxt;
    out_hit_r    <= out_hit_nxt;
    out_slot_r   <= out_slot_nxt;
    out_key_r    <= out_key_nxt;
  end

  // Only one request is in work: an accepted request closes the input.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("request accepted while another is in work");

  // The slot under check always lies inside the table.
  a_chk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    chk_vld_r |-> (32'(chk_idx_r) < ENTRIES_W))
    else $error("scan checked a slot beyond the table");

  // An insert that meets a free slot writes it next.
  a_free_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && chk_vld_r && cmd_r == CMD_INSERT && !rdata_r.occ)
    |=> (state_r == ST_WRITE && target_r == $past(chk_idx_r)))
    else $error("insert skipped a free slot");

  // Every slot write of an insert advances the insertion clock by one.
  a_clock_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE) |=> (clock_r == $past(clock_r) + 32'd1))
    else $error("insertion clock did not advance on insert");

endmodule

`default_nettype wire

[test/skipped_key_store_check.sv]
// ----------------------------------------------------------------------------
// skipped_key_store_check: response checker for the skipped key store
// Keeps its own copy of the slot table, predicts the response to every
// accepted request and compares each delivered response field by field.
// ----------------------------------------------------------------------------

module skipped_key_store_check #(
  parameter int ENTRIES = 32
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  input  wire                          in_tready,
  input  wire  [sks_pkg::InDataW-1:0]  in_tdata,
  input  wire                          out_tvalid,
  input  wire                          out_tready,
  input  wire  [sks_pkg::OutDataW-1:0] out_tdata,
  output int                           mismatch_count,
  output int                           responses_owed
);
  import sks_pkg::*;

  localparam int ReportLimit = 200;

  typedef struct packed {
    logic [PopW-1:0] pop_slot;
    logic [KeyW-1:0] msg_key;
    logic [NumW-1:0] msg_number;
    logic [KeyW-1:0] hdr_key;
    logic [CmdW-1:0] cmd;
  } key_request_t;

  typedef struct packed {
    logic [KeyW-1:0]  msg_key;
    logic [SlotW-1:0] slot;
    logic             hit;
  } key_response_t;

  logic              occupied [ENTRIES];
  logic [NumW-1:0]   number   [ENTRIES];
  logic [KeyW-1:0]   header   [ENTRIES];
  logic [KeyW-1:0]   message  [ENTRIES];
  logic [StampW-1:0] stamp    [ENTRIES];
  logic [StampW-1:0] insert_count;
  key_response_t     expected_responses [$];
  int                failures = 0;

  // Applies one request to the mirrored table and returns its response.
  function automatic key_response_t apply_request(key_request_t req);
    key_response_t rsp;
    int            target;
    rsp = '0;
    case (req.cmd)
      CMD_FIND: begin
        for (int s = 0; s < ENTRIES; s++) begin
          if (!rsp.hit && occupied[s] && number[s] == req.msg_number &&
              header[s] == req.hdr_key) begin
            rsp.hit  = 1'b1;
            rsp.slot = s[SlotW-1:0];
          end
        end
      end
      CMD_INSERT: begin
        target = -1;
        for (int s = ENTRIES - 1; s >= 0; s--)
          if (!occupied[s]) target = s;
        // Full table: the oldest stamp goes, lowest index on ties.
        if (target < 0) begin
          target = 0;
          for (int s = 1; s < ENTRIES; s++)
            if (stamp[s] < stamp[target]) target = s;
        end
        header[target]   = req.hdr_key;
        message[target]  = req.msg_key;
        number[target]   = req.msg_number;
        occupied[target] = 1'b1;
        insert_count     = insert_count + 1'b1;
        stamp[target]    = insert_count;
        rsp.slot         = target[SlotW-1:0];
      end
      CMD_POP: begin
        // The stamp of a popped slot is left as it was.
        if (req.pop_slot < ENTRIES) begin
          rsp.msg_key                = message[req.pop_slot];
          message[req.pop_slot]      = '0;
          header[req.pop_slot]       = '0;
          number[req.pop_slot]       = '0;
          occupied[req.pop_slot]     = 1'b0;
        end
      end
      default: begin
      end
    endcase
    return rsp;
  endfunction

  task automatic compare_field(input string name, input logic [63:0] want_v,
                               input logic [63:0] seen_v, inout logic bad);
    if (want_v !== seen_v) begin
      bad = 1'b1;
      if (failures < ReportLimit)
        $display("%0t: %s expected %h, got %h", $time, name, want_v, seen_v);
    end
  endtask

  always @(posedge clk) begin
    key_response_t seen;
    key_response_t want;
    logic          bad;
    if (!rst_n) begin
      for (int s = 0; s < ENTRIES; s++) begin
        occupied[s] = 1'b0;
        number[s]   = '0;
        header[s]   = '0;
        message[s]  = '0;
        stamp[s]    = '0;
      end
      insert_count = '0;
      expected_responses.delete();
      responses_owed <= 0;
    end else begin
      // Responses are checked before new requests are queued, so a response
      // arriving with nothing owed is caught even when a request lands too.
      if (out_tvalid && out_tready) begin
        seen = out_tdata[$bits(key_response_t)-1:0];
        if (expected_responses.size() == 0) begin
          if (failures < ReportLimit)
            $display("%0t: response expected none, got %h", $time, seen);
          failures++;
        end else begin
          want = expected_responses.pop_front();
          bad  = 1'b0;
          compare_field("hit", 64'(want.hit), 64'(seen.hit), bad);
          compare_field("result_slot", 64'(want.slot), 64'(seen.slot), bad);
          for (int w = 0; w < 4; w++)
            compare_field($sformatf("result_key_w%0d", w), want.msg_key[w*64 +: 64],
                          seen.msg_key[w*64 +: 64], bad);
          if (bad) failures++;
        end
        mismatch_count <= failures;
      end
      if (in_tvalid && in_tready)
        expected_responses.push_back(apply_request(in_tdata[$bits(key_request_t)-1:0]));
      responses_owed <= expected_responses.size();
    end
  end

endmodule

[test/skipped_key_store_test.sv]
// ----------------------------------------------------------------------------
// skipped_key_store_test: stimulus and verdict for the skipped key store
// Drives a directed opening and then randomized find, insert and pop traffic
// with random gaps on both sides and one long output stall; a separate
// checker predicts and compares every response.
// ----------------------------------------------------------------------------

module skipped_key_store_test;
  import sks_pkg::*;

  localparam int Entries        = 32;
  localparam int RandomRequests = 1450;
  localparam int ChunkSize      = 50;
  // The limit allows for the slowest request, an insert that scans every
  // stamp, plus the idle gaps on each side, for every request.
  localparam int CycleLimit     = 400000;
  localparam int TailCycles     = 2 * (Entries + 8);
  localparam int HoldOffAfter   = 300;
  localparam int HoldOffCycles  = 400;
  localparam int RecentDepth    = 48;

  // Command code 3 is unused by the block; it must answer with all zeros.
  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;
  int                  mismatch_count;
  int                  responses_owed;
  int                  cycle_count;
  bit                  sender_burst;

  // A few header keys shared by many messages, as in a real session, so that
  // finds can match on one key and miss on the other.
  logic [KeyW-1:0]     header_pool [4];
  // Keys of recent inserts; most finds look one of these up.
  logic [KeyW-1:0]     recent_hdr [$];
  logic [NumW-1:0]     recent_num [$];

  skipped_key_store #(
    .ENTRIES (Entries)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  skipped_key_store_check #(
    .ENTRIES (Entries)
  ) response_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .responses_owed (responses_owed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [KeyW-1:0] random_key();
    return {$urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom};
  endfunction

  // Message numbers cluster in a small range so that the same header and
  // number pair gets stored twice now and then; the rest spans the full width.
  function automatic logic [NumW-1:0] random_number();
    logic [NumW-1:0] num;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: num = $urandom_range(0, 15);
      5:             num = '1;
      default:       num = $urandom;
    endcase
    return num;
  endfunction

  // Offers one request after a random gap and holds it until it is taken.
  // With a zero gap in_tvalid simply stays high from the previous request.
  task automatic send_request(input logic [CmdW-1:0] cmd, input logic [KeyW-1:0] hdr,
                              input logic [NumW-1:0] num, input logic [KeyW-1:0] mkey,
                              input logic [PopW-1:0] slot);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    // pop_slot, msg_key, msg_number, hdr_key and cmd from the top down.
    in_tdata  <= {1'b0, slot, mkey, num, hdr, cmd};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (cmd == CMD_INSERT) begin
      recent_hdr.push_back(hdr);
      recent_num.push_back(num);
      if (recent_hdr.size() > RecentDepth) begin
        recent_hdr.pop_front();
        recent_num.pop_front();
      end
    end
  endtask

  // One random request. Fields a command does not use still carry random
  // values, so that the block is seen to ignore them.
  task automatic send_random_request(input int insert_pct, input int pop_pct);
    int              roll;
    int              pick;
    int              flip;
    logic [KeyW-1:0] hdr;
    logic [NumW-1:0] num;
    roll = $urandom_range(0, 99);
    hdr  = header_pool[$urandom_range(0, 3)];
    if ($urandom_range(0, 7) == 0) hdr = random_key();
    num  = random_number();
    if (roll < insert_pct) begin
      send_request(CMD_INSERT, hdr, num, random_key(), PopW'($urandom_range(0, 31)));
    end else if (roll < insert_pct + pop_pct) begin
      send_request(CMD_POP, random_key(), $urandom, random_key(),
                   PopW'($urandom_range(0, 31)));
    end else if (roll < 95) begin
      // Mostly an exact lookup of a recent insert (which may have been popped
      // or evicted since), sometimes one bit off in the header or the number.
      if (recent_hdr.size() != 0 && $urandom_range(0, 99) < 85) begin
        pick = $urandom_range(0, recent_hdr.size() - 1);
        hdr  = recent_hdr[pick];
        num  = recent_num[pick];
        case ($urandom_range(0, 5))
          0: begin
            flip      = $urandom_range(0, KeyW - 1);
            hdr[flip] = ~hdr[flip];
          end
          1: begin
            flip      = $urandom_range(0, NumW - 1);
            num[flip] = ~num[flip];
          end
          default: begin
          end
        endcase
      end
      send_request(CMD_FIND, hdr, num, random_key(), PopW'($urandom_range(0, 31)));
    end else begin
      send_request(CMD_UNUSED, random_key(), $urandom, random_key(),
                   PopW'($urandom_range(0, 31)));
    end
  endtask

  // Receiver: waits a random gap before each response, with runs of no
  // waiting at all. After a few hundred responses it refuses for a long
  // stretch, so the block fills its output stage and drops in_tready.
  initial begin
    int gap;
    int taken;
    bit burst;
    taken = 0;
    burst = 1'b0;
    out_tready <= 1'b0;
    wait (rst_n);
    forever begin
      if (taken % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      gap = burst ? 0 : $urandom_range(0, 6);
      if (taken == HoldOffAfter) gap = HoldOffCycles;
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  // Watchdog on the whole run; it also covers the clearing sweep after reset.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("skipped_key_store_test NOT OK");
    $finish;
  end

  initial begin
    logic [KeyW-1:0] spare;
    bit              fill;
    rst_n        <= 1'b0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    sender_burst  = 1'b0;
    // The all-zero header also matches what a cleared slot holds.
    header_pool[0] = '0;
    for (int i = 1; i < 4; i++) header_pool[i] = random_key();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening. A find on the empty table misses even for the
    // all-zero key that every free slot holds.
    send_request(CMD_FIND, '0, '0, '0, '0);
    send_request(CMD_INSERT, '0, '0, '1, '0);            // lands in slot 0
    send_request(CMD_FIND, '0, '0, '0, '0);              // hit on slot 0
    send_request(CMD_INSERT, '1, '1, '0, '1);            // slot 1, extreme keys
    send_request(CMD_FIND, '1, '1, '0, '0);              // hit on slot 1
    // Header matches but the number is one off, then the reverse.
    send_request(CMD_FIND, '1, {{(NumW-1){1'b1}}, 1'b0}, '0, '0);
    send_request(CMD_FIND, {1'b0, {(KeyW-1){1'b1}}}, '1, '0, '0);
    // Storing the same pair twice: a find must report the lower slot.
    spare = random_key();
    send_request(CMD_INSERT, '0, '0, spare, '0);         // slot 2
    send_request(CMD_FIND, '0, '0, '0, '0);              // still slot 0
    send_request(CMD_POP, '0, '0, '0, 5'd0);             // returns all ones
    send_request(CMD_FIND, '0, '0, '0, '0);              // now slot 2
    // Popping a free slot returns zero, including the top slot.
    send_request(CMD_POP, '0, '0, '0, 5'd0);
    send_request(CMD_POP, '1, '1, '1, '1);
    // The unused command code changes nothing and answers with zeros.
    send_request(CMD_UNUSED, '1, '1, '1, '1);
    // The lowest free slot is taken again after a pop.
    send_request(CMD_INSERT, header_pool[2], 32'h8000_0000, random_key(), '0);
    send_request(CMD_FIND, header_pool[2], 32'h8000_0000, '0, '0);
    send_request(CMD_POP, '0, '0, '0, 5'd2);
    send_request(CMD_POP, '0, '0, '0, 5'd1);
    send_request(CMD_FIND, '1, '1, '0, '0);              // miss after the pop

    // Random part in chunks that either fill the table, forcing evictions
    // of the oldest slot, or drain it with pops. The first chunk fills.
    for (int chunk = 0; chunk < RandomRequests / ChunkSize; chunk++) begin
      fill         = (chunk == 0) || ($urandom_range(0, 1) == 1);
      sender_burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < ChunkSize; i++) begin
        if (fill) send_random_request(55, 12);
        else      send_random_request(20, 45);
      end
    end
    in_tvalid <= 1'b0;

    // Step the clock first so the owed count includes the last request.
    @(posedge clk);
    while (responses_owed != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (mismatch_count == 0 && responses_owed == 0) begin
      $display("skipped_key_store_test OK");
    end else begin
      $display("skipped_key_store_test NOT OK");
    end
    $finish;
  end

endmodule
